// ===== rtl/ppz_pkg.sv =====
// Shared constants and types for the point projection depth buffer.
package ppz_pkg;

	localparam int DepthW = 16;
	localparam int NumW   = 52;
	localparam int QuotW  = 51;
	localparam int ProdW  = 50;

	typedef logic [1:0] op_t;
	localparam op_t OP_LOAD    = 2'd0;
	localparam op_t OP_PROJECT = 2'd1;
	localparam op_t OP_READ    = 2'd2;
	localparam op_t OP_NONE    = 2'd3;

	typedef logic [2:0] reg_idx_t;
	localparam reg_idx_t REG_FOCAL_X  = 3'd0;
	localparam reg_idx_t REG_SKEW     = 3'd1;
	localparam reg_idx_t REG_CENTER_X = 3'd2;
	localparam reg_idx_t REG_FOCAL_Y  = 3'd3;
	localparam reg_idx_t REG_CENTER_Y = 3'd4;
	localparam reg_idx_t REG_COLS     = 3'd5;
	localparam reg_idx_t REG_ROWS     = 3'd6;

endpackage

// ===== rtl/point_projection_zbuffer.sv =====
// Point projection through pinhole intrinsics into a nearest-wins depth buffer.
//
// After reset the block sweeps the depth memory to zero, one pixel a cycle,
// with busy high; configuration writes are taken throughout. Items are then
// accepted on start while busy is low and each gives one result, shown for
// one cycle with done. A load or an unused code answers in the cycle after
// acceptance; a read goes through the read state for the registered memory
// output. A project item runs five products through one shared 25x25
// multiplier, 51 steps of a bit-serial divider for column and row together,
// and, for a point in view, a read-modify-write of the depth memory. A point
// with non-positive depth answers in the cycle after acceptance.
module point_projection_zbuffer
	import ppz_pkg::*;
#(
	parameter int MAX_COLS = 1024,
	parameter int MAX_ROWS = 512
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	input  logic [1:0]               operation,
	input  logic [9:0]               pixel_col,
	input  logic [8:0]               pixel_row,
	input  logic [15:0]              depth_in,
	input  logic signed [23:0]       x_coord,
	input  logic signed [23:0]       y_coord,
	input  logic signed [23:0]       z_coord,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [2:0]               cfg_index,
	input  logic [23:0]              cfg_data,
	output logic                     done,
	output logic                     in_view,
	output logic                     written,
	output logic [9:0]               out_col,
	output logic [8:0]               out_row,
	output logic [15:0]              depth_out
);

	localparam int Depth = MAX_COLS * MAX_ROWS;
	localparam int AW    = $clog2(Depth);

	localparam logic [2:0] ST_CLR  = 3'd0;
	localparam logic [2:0] ST_IDLE = 3'd1;
	localparam logic [2:0] ST_RD   = 3'd2;
	localparam logic [2:0] ST_MUL  = 3'd3;
	localparam logic [2:0] ST_PRE  = 3'd4;
	localparam logic [2:0] ST_DIV  = 3'd5;
	localparam logic [2:0] ST_CHK  = 3'd6;
	localparam logic [2:0] ST_RMW  = 3'd7;

	logic [2:0]               state_q;
	logic [AW-1:0]            clr_q;
	logic [23:0]              focal_x_q, center_x_q, focal_y_q, center_y_q;
	logic signed [23:0]       skew_q;
	logic [10:0]              cols_q;
	logic [9:0]               rows_q;
	logic signed [23:0]       x_q, y_q;
	logic [22:0]              z_q;
	logic [DepthW-1:0]        cand_q;
	logic [2:0]               step_q;
	logic [5:0]               div_cnt_q;
	logic signed [ProdW-1:0]  prod_s1;
	logic signed [NumW-1:0]   nx_q, ny_q;
	logic [QuotW-1:0]         qx_q, qy_q;
	logic [23:0]              rx_q, ry_q;
	logic [AW-1:0]            addr_q;
	logic                     rd_ok_q;
	logic                     done_q, in_view_q, written_q;
	logic [9:0]               col_q;
	logic [8:0]               row_q;
	logic [DepthW-1:0]        dep_q;

	logic                     accept, in_bounds, wr_new;
	logic [AW-1:0]            addr_in, addr_chk, ram_waddr, ram_raddr;
	logic                     ram_we;
	logic [DepthW-1:0]        ram_wdata, ram_rdata;
	logic signed [24:0]       mul_a, mul_b;
	logic [23:0]              tx, ty;
	logic                     bx, by;
	logic [31:0]              cols_lim, rows_lim;
	logic                     vis;
	logic [11:0]              col_w, row_w;

	assign accept    = start && !busy;
	assign busy      = (state_q != ST_IDLE);
	assign cfg_ready = 1'b1;

	assign in_bounds = (32'(pixel_col) < 32'(MAX_COLS)) && (32'(pixel_row) < 32'(MAX_ROWS));
	assign addr_in   = AW'(AW'(pixel_row) * AW'(MAX_COLS) + AW'(pixel_col));

	assign cols_lim = (32'(cols_q) > 32'(MAX_COLS)) ? 32'(MAX_COLS) : 32'(cols_q);
	assign rows_lim = (32'(rows_q) > 32'(MAX_ROWS)) ? 32'(MAX_ROWS) : 32'(rows_q);
	assign vis = (qx_q != '0) && (qx_q < QuotW'({cols_lim, 8'h00}))
		&& (qy_q != '0) && (qy_q < QuotW'({rows_lim, 8'h00}));
	assign col_w    = qx_q[19:8];
	assign row_w    = qy_q[19:8];
	assign addr_chk = AW'(AW'(row_w) * AW'(MAX_COLS) + AW'(col_w));

	assign wr_new = (ram_rdata == '0) || (cand_q < ram_rdata);

	always_comb begin
		unique case (step_q)
			3'd0: begin
				mul_a = {1'b0, focal_x_q};
				mul_b = {x_q[23], x_q};
			end
			3'd1: begin
				mul_a = {skew_q[23], skew_q};
				mul_b = {y_q[23], y_q};
			end
			3'd2: begin
				mul_a = {1'b0, center_x_q};
				mul_b = {2'b00, z_q};
			end
			3'd3: begin
				mul_a = {1'b0, focal_y_q};
				mul_b = {y_q[23], y_q};
			end
			default: begin
				mul_a = {1'b0, center_y_q};
				mul_b = {2'b00, z_q};
			end
		endcase
	end

	assign tx = {rx_q[22:0], qx_q[QuotW-1]};
	assign ty = {ry_q[22:0], qy_q[QuotW-1]};
	assign bx = (tx >= {1'b0, z_q});
	assign by = (ty >= {1'b0, z_q});

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = addr_in;
		ram_wdata = depth_in;
		priority if (state_q == ST_CLR) begin
			ram_we    = 1'b1;
			ram_waddr = clr_q;
			ram_wdata = '0;
		end else if (state_q == ST_RMW) begin
			ram_we    = wr_new;
			ram_waddr = addr_q;
			ram_wdata = cand_q;
		end else if (accept && (op_t'(operation) == OP_LOAD) && in_bounds) begin
			ram_we = 1'b1;
		end
	end

	assign ram_raddr = (state_q == ST_CHK) ? addr_chk : addr_in;

	ppz_ram #(
		.Width(DepthW),
		.Depth(Depth)
	) u_depth_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			focal_x_q  <= 24'd128000;
			skew_q     <= '0;
			center_x_q <= 24'd81920;
			focal_y_q  <= 24'd128000;
			center_y_q <= 24'd61440;
			cols_q     <= 11'd640;
			rows_q     <= 10'd480;
		end else if (cfg_valid && cfg_ready) begin
			unique case (reg_idx_t'(cfg_index))
				REG_FOCAL_X:  focal_x_q  <= cfg_data;
				REG_SKEW:     skew_q     <= cfg_data;
				REG_CENTER_X: center_x_q <= cfg_data;
				REG_FOCAL_Y:  focal_y_q  <= cfg_data;
				REG_CENTER_Y: center_y_q <= cfg_data;
				REG_COLS:     cols_q     <= cfg_data[10:0];
				REG_ROWS:     rows_q     <= cfg_data[9:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLR;
			clr_q     <= '0;
			done_q    <= 1'b0;
			step_q    <= '0;
			div_cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_CLR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(Depth - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						unique case (op_t'(operation))
							OP_LOAD: begin
								done_q <= 1'b1;
							end
							OP_READ: begin
								state_q <= ST_RD;
							end
							OP_PROJECT: begin
								if (z_coord > 0) begin
									state_q <= ST_MUL;
									step_q  <= '0;
								end else begin
									done_q <= 1'b1;
								end
							end
							default: begin
								done_q <= 1'b1;
							end
						endcase
					end
				end
				ST_RD: begin
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				ST_MUL: begin
					step_q <= step_q + 3'd1;
					if (step_q == 3'd5) begin
						state_q <= ST_PRE;
					end
				end
				ST_PRE: begin
					div_cnt_q <= '0;
					state_q   <= ST_DIV;
				end
				ST_DIV: begin
					div_cnt_q <= div_cnt_q + 6'd1;
					if (div_cnt_q == 6'(QuotW - 1)) begin
						state_q <= ST_CHK;
					end
				end
				ST_CHK: begin
					if (vis) begin
						state_q <= ST_RMW;
					end else begin
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				ST_RMW: begin
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= mul_a * mul_b;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					x_q       <= x_coord;
					y_q       <= y_coord;
					z_q       <= z_coord[22:0];
					cand_q    <= (|z_coord[22:16]) ? 16'hFFFF : z_coord[15:0];
					nx_q      <= '0;
					ny_q      <= '0;
					rd_ok_q   <= in_bounds;
					in_view_q <= 1'b0;
					unique case (op_t'(operation))
						OP_LOAD: begin
							written_q <= in_bounds;
							col_q     <= pixel_col;
							row_q     <= pixel_row;
							dep_q     <= in_bounds ? depth_in : '0;
						end
						OP_READ: begin
							written_q <= 1'b0;
							col_q     <= pixel_col;
							row_q     <= pixel_row;
						end
						default: begin
							written_q <= 1'b0;
							col_q     <= '0;
							row_q     <= '0;
							dep_q     <= '0;
						end
					endcase
				end
			end
			ST_RD: begin
				dep_q <= rd_ok_q ? ram_rdata : '0;
			end
			ST_MUL: begin
				if (step_q >= 3'd1 && step_q <= 3'd3) begin
					nx_q <= nx_q + NumW'(prod_s1);
				end else if (step_q >= 3'd4) begin
					ny_q <= ny_q + NumW'(prod_s1);
				end
			end
			ST_PRE: begin
				qx_q <= (nx_q > 0) ? nx_q[QuotW-1:0] : '0;
				qy_q <= (ny_q > 0) ? ny_q[QuotW-1:0] : '0;
				rx_q <= '0;
				ry_q <= '0;
			end
			ST_DIV: begin
				rx_q <= bx ? (tx - {1'b0, z_q}) : tx;
				ry_q <= by ? (ty - {1'b0, z_q}) : ty;
				qx_q <= {qx_q[QuotW-2:0], bx};
				qy_q <= {qy_q[QuotW-2:0], by};
			end
			ST_CHK: begin
				addr_q    <= addr_chk;
				in_view_q <= vis;
				written_q <= 1'b0;
				col_q     <= vis ? col_w[9:0] : '0;
				row_q     <= vis ? row_w[8:0] : '0;
				dep_q     <= '0;
			end
			ST_RMW: begin
				written_q <= wr_new;
				dep_q     <= wr_new ? cand_q : ram_rdata;
			end
			default: ;
		endcase
	end

	assign done      = done_q;
	assign in_view   = in_view_q;
	assign written   = written_q;
	assign out_col   = col_q;
	assign out_row   = row_q;
	assign depth_out = dep_q;

`ifndef ASSERT_OFF
	a_view_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		done && in_view |-> depth_out != '0)
		else $error("projected result with empty depth");
	a_rmw_order: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_RMW |-> $past(state_q) == ST_CHK)
		else $error("depth update without a preceding check");
	a_clear_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CLR |-> !done)
		else $error("result during clearing sweep");
	a_view_no_load: assert property (@(posedge clk) disable iff (!arst_n)
		done && in_view |-> $past(state_q) == ST_RMW)
		else $error("in view flagged outside a depth update");
`endif

endmodule

// ===== rtl/ppz_ram.sv =====
// Generic simple dual-port RAM with registered read.
module ppz_ram #(
	parameter int Width = 16,
	parameter int Depth = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);

	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== dv/tb_point_projection_zbuffer.sv =====
// Self-checking testbench for the point projection depth buffer: directed rows, then random traffic.
module tb_point_projection_zbuffer;
	import ppz_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int  IMG_COLS  = 1024;
	localparam int  IMG_ROWS  = 512;
	localparam int  IMG_SIZE  = IMG_COLS * IMG_ROWS;
	localparam int  IDLE_MAX  = 4 * IMG_SIZE;
	localparam int  PER_PHASE = 205;
	localparam int  NPHASE    = 7;

	typedef struct packed {
		logic        in_view;
		logic        written;
		logic [9:0]  col;
		logic [8:0]  row;
		logic [15:0] depth;
	} pix_res_t;

	typedef struct packed {
		op_t                op;
		logic [9:0]         col;
		logic [8:0]         row;
		logic [15:0]        din;
		logic signed [23:0] x;
		logic signed [23:0] y;
		logic signed [23:0] z;
		logic               typed;
		pix_res_t           want;
	} item_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic               busy;
	logic [1:0]         operation = OP_NONE;
	logic [9:0]         pixel_col = '0;
	logic [8:0]         pixel_row = '0;
	logic [15:0]        depth_in = '0;
	logic signed [23:0] x_coord = '0;
	logic signed [23:0] y_coord = '0;
	logic signed [23:0] z_coord = '0;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [2:0]         cfg_index = '0;
	logic [23:0]        cfg_data = '0;
	logic               done;
	logic               in_view;
	logic               written;
	logic [9:0]         out_col;
	logic [8:0]         out_row;
	logic [15:0]        depth_out;

	logic     row_typed = 1'b0;
	pix_res_t row_want = '0;

	point_projection_zbuffer dut (.*);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// predictor copy of the block
	logic [15:0] depth_img [IMG_SIZE];
	longint      k_fx, k_skew, k_cx, k_fy, k_cy, k_cols, k_rows;

	pix_res_t    pending_q[$];
	int          fails = 0;
	int          n_items = 0;
	int          n_results = 0;
	int          n_in_view = 0;
	int          n_written = 0;
	int          idle_cycles = 0;

	function automatic void apply_reg(reg_idx_t idx, logic [23:0] val);
		case (idx)
			REG_FOCAL_X:  k_fx = longint'(val);
			REG_SKEW:     k_skew = longint'(signed'(val));
			REG_CENTER_X: k_cx = longint'(val);
			REG_FOCAL_Y:  k_fy = longint'(val);
			REG_CENTER_Y: k_cy = longint'(val);
			REG_COLS:     k_cols = longint'(val[10:0]);
			REG_ROWS:     k_rows = longint'(val[9:0]);
			default: ;
		endcase
	endfunction

	function automatic pix_res_t project_pixel(op_t op, logic [9:0] pc, logic [8:0] pr,
			logic [15:0] din, logic signed [23:0] xi, logic signed [23:0] yi,
			logic signed [23:0] zi);
		pix_res_t r;
		longint   x, y, z, nx, ny, qx, qy, cols, rows, dep;
		int       a;
		r = '0;
		x = longint'(xi);
		y = longint'(yi);
		z = longint'(zi);
		case (op)
			OP_LOAD: begin
				a = int'(pr) * IMG_COLS + int'(pc);
				depth_img[a] = din;
				r = '{1'b0, 1'b1, pc, pr, din};
			end
			OP_READ: begin
				a = int'(pr) * IMG_COLS + int'(pc);
				r = '{1'b0, 1'b0, pc, pr, depth_img[a]};
			end
			OP_PROJECT: begin
				cols = k_cols > IMG_COLS ? IMG_COLS : k_cols;
				rows = k_rows > IMG_ROWS ? IMG_ROWS : k_rows;
				if (z > 0) begin
					nx = k_fx * x + k_skew * y + k_cx * z;
					ny = k_fy * y + k_cy * z;
					qx = nx / z;
					qy = ny / z;
					if (qx > 0 && qx < cols * 256 && qy > 0 && qy < rows * 256) begin
						dep = z > 65535 ? 65535 : z;
						a = int'(qy >>> 8) * IMG_COLS + int'(qx >>> 8);
						r.in_view = 1'b1;
						r.col = qx[17:8];
						r.row = qy[16:8];
						if (depth_img[a] == 0 || dep < depth_img[a]) begin
							depth_img[a] = dep[15:0];
							r.written = 1'b1;
						end
						r.depth = depth_img[a];
					end
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	// acceptance, checking and watchdog
	always @(posedge clk) begin
		pix_res_t exp_r, got, pred;
		if (arst_n) begin
			if (done) begin
				got = '{in_view, written, out_col, out_row, depth_out};
				n_results++;
				if (pending_q.size() == 0) begin
					$display("%0t: result with nothing expected: %p", $realtime, got);
					fails++;
				end else begin
					exp_r = pending_q.pop_front();
					if (got.in_view !== exp_r.in_view) begin
						$display("%0t: in_view exp %0d act %0d", $realtime, exp_r.in_view, got.in_view);
						fails++;
					end
					if (got.written !== exp_r.written) begin
						$display("%0t: written exp %0d act %0d", $realtime, exp_r.written, got.written);
						fails++;
					end
					if (got.col !== exp_r.col) begin
						$display("%0t: out_col exp %0d act %0d", $realtime, exp_r.col, got.col);
						fails++;
					end
					if (got.row !== exp_r.row) begin
						$display("%0t: out_row exp %0d act %0d", $realtime, exp_r.row, got.row);
						fails++;
					end
					if (got.depth !== exp_r.depth) begin
						$display("%0t: depth_out exp %0d act %0d", $realtime, exp_r.depth, got.depth);
						fails++;
					end
				end
			end
			if (start && !busy) begin
				pred = project_pixel(op_t'(operation), pixel_col, pixel_row, depth_in,
					x_coord, y_coord, z_coord);
				pending_q = {pending_q, (row_typed ? row_want : pred)};
				n_items++;
				n_in_view += int'(pred.in_view);
				n_written += int'(pred.written);
			end
			if (cfg_valid && cfg_ready)
				apply_reg(reg_idx_t'(cfg_index), cfg_data);
			if (done || (start && !busy) || (cfg_valid && cfg_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles > IDLE_MAX) begin
				$display("%0t: watchdog, no transaction for %0d cycles", $realtime, idle_cycles);
				$display("tb_point_projection_zbuffer: FAIL");
				$finish;
			end
		end
	end

	// stimulus helpers
	int          quiet = 0;
	longint      pool_qx [8];
	longint      pool_qy [8];

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (quiet != 0 || r < 50)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic signed [23:0] clamp24(longint v);
		if (v > 8388607)
			return 24'sd8388607;
		if (v < -8388608)
			return -24'sd8388608;
		return v[23:0];
	endfunction

	function automatic item_t random_item();
		item_t  it;
		int     r, s;
		longint cols, rows, tqx, tqy, z, y;
		it = '0;
		it.col = 10'($urandom);
		it.row = 9'($urandom);
		it.din = 16'($urandom);
		it.x = 24'($urandom);
		it.y = 24'($urandom);
		it.z = 24'($urandom);
		cols = k_cols > IMG_COLS ? IMG_COLS : (k_cols == 0 ? 1 : k_cols);
		rows = k_rows > IMG_ROWS ? IMG_ROWS : (k_rows == 0 ? 1 : k_rows);
		s = $urandom_range(0, 7);
		if ($urandom_range(0, 99) < 35) begin
			tqx = pool_qx[s];
			tqy = pool_qy[s];
		end else begin
			tqx = longint'($urandom_range(0, int'(cols * 256)));
			tqy = longint'($urandom_range(0, int'(rows * 256)));
			pool_qx[s] = tqx;
			pool_qy[s] = tqy;
		end
		r = $urandom_range(0, 99);
		if (r < 60) begin
			it.op = OP_PROJECT;
			z = ($urandom_range(0, 9) < 7) ? longint'($urandom_range(1, 70000))
				: longint'($urandom_range(1, 8388607));
			y = k_fy != 0 ? ((tqy - k_cy) * z) / k_fy : longint'(it.y);
			it.y = clamp24(y);
			if (k_fx != 0)
				it.x = clamp24(((tqx - k_cx) * z - k_skew * longint'(it.y)) / k_fx);
			it.z = z[23:0];
		end else if (r < 70) begin
			it.op = OP_PROJECT;
		end else if (r < 94) begin
			it.op = r < 82 ? OP_LOAD : OP_READ;
			if ($urandom_range(0, 1)) begin
				it.col = tqx[17:8];
				it.row = tqy[16:8];
			end
		end else begin
			it.op = OP_NONE;
		end
		return it;
	endfunction

	task automatic send_item(item_t it);
		int g;
		g = pick_gap();
		if (g > 0) begin
			start <= 1'b0;
			repeat (g) @(posedge clk);
		end
		start <= 1'b1;
		operation <= it.op;
		pixel_col <= it.col;
		pixel_row <= it.row;
		depth_in <= it.din;
		x_coord <= it.x;
		y_coord <= it.y;
		z_coord <= it.z;
		row_typed <= it.typed;
		row_want <= it.want;
		forever begin
			@(negedge clk);
			if (!busy)
				break;
		end
		@(posedge clk);
	endtask

	task automatic write_reg(reg_idx_t idx, logic [23:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		forever begin
			@(negedge clk);
			if (cfg_ready)
				break;
		end
		@(posedge clk);
	endtask

	task automatic drain();
		start <= 1'b0;
		row_typed <= 1'b0;
		@(negedge clk);
		while (pending_q.size() != 0)
			@(negedge clk);
		repeat (8) @(posedge clk);
	endtask

	function automatic item_t mk(op_t op, int c, int rw, int d, int x, int y, int z,
			bit typed = 0, pix_res_t want = '0);
		item_t it;
		it = '{op, c[9:0], rw[8:0], d[15:0], x[23:0], y[23:0], z[23:0], typed, want};
		return it;
	endfunction

	item_t       directed_rows[$];
	logic [23:0] phase_regs [NPHASE][7];

	function automatic void add_row(item_t it);
		directed_rows = {directed_rows, it};
	endfunction

	initial begin
		for (int i = 0; i < IMG_SIZE; i++)
			depth_img[i] = '0;
		k_fx = 128000;
		k_skew = 0;
		k_cx = 81920;
		k_fy = 128000;
		k_cy = 61440;
		k_cols = 640;
		k_rows = 480;
		for (int i = 0; i < 8; i++) begin
			pool_qx[i] = 81920;
			pool_qy[i] = 61440;
		end

		phase_regs[0] = '{24'd128000, 24'd0, 24'd81920, 24'd128000, 24'd61440, 24'd640, 24'd480};
		phase_regs[1] = '{24'd300000, -24'sd5000, 24'd100000, 24'd250000, 24'd40000,
			24'd1024, 24'd512};
		phase_regs[2] = '{24'hFFFFFF, 24'h7FFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF,
			24'd2047, 24'd1023};
		phase_regs[3] = '{24'd0, 24'h800000, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0};
		phase_regs[4] = '{24'd1, 24'd0, 24'd1280, 24'd1, 24'd768, 24'd1, 24'd1};
		for (int p = 5; p < NPHASE; p++) begin
			phase_regs[p][0] = 24'($urandom_range(20000, 400000));
			phase_regs[p][1] = 24'($signed($urandom_range(0, 40000)) - 20000);
			phase_regs[p][3] = 24'($urandom_range(20000, 400000));
			phase_regs[p][5] = 24'($urandom_range(16, 1024));
			phase_regs[p][6] = 24'($urandom_range(16, 512));
			phase_regs[p][2] = 24'($urandom_range(0, phase_regs[p][5] * 256));
			phase_regs[p][4] = 24'($urandom_range(0, phase_regs[p][6] * 256));
		end

		add_row(mk(OP_READ, 0, 0, 0, 0, 0, 0, 1, '0));
		add_row(mk(OP_READ, 1023, 511, 0, 0, 0, 0, 1,
			'{1'b0, 1'b0, 10'd1023, 9'd511, 16'd0}));
		add_row(mk(OP_LOAD, 1023, 511, 65535, 0, 0, 0, 1,
			'{1'b0, 1'b1, 10'd1023, 9'd511, 16'd65535}));
		add_row(mk(OP_READ, 1023, 511, 0, 0, 0, 0, 1,
			'{1'b0, 1'b0, 10'd1023, 9'd511, 16'd65535}));
		add_row(mk(OP_LOAD, 0, 0, 0, 0, 0, 0, 1, '{1'b0, 1'b1, 10'd0, 9'd0, 16'd0}));
		add_row(mk(OP_NONE, 1023, 511, 65535, -1, -1, -1, 1, '0));
		add_row(mk(OP_PROJECT, 5, 5, 5, 0, 0, 0, 1, '0));
		add_row(mk(OP_PROJECT, 0, 0, 0, 8388607, 8388607, -8388608, 1, '0));
		add_row(mk(OP_PROJECT, 0, 0, 0, 0, 0, 8388607));
		add_row(mk(OP_PROJECT, 0, 0, 0, 0, 0, 1000));
		add_row(mk(OP_PROJECT, 0, 0, 0, 0, 0, 2000));
		add_row(mk(OP_PROJECT, 0, 0, 0, 0, 0, 1000));
		add_row(mk(OP_PROJECT, 0, 0, 0, 0, 0, 500));
		add_row(mk(OP_READ, 320, 240, 0, 0, 0, 0));
		add_row(mk(OP_PROJECT, 0, 0, 0, -640, 0, 1000));
		add_row(mk(OP_PROJECT, 0, 0, 0, 640, 0, 1000));
		add_row(mk(OP_PROJECT, 0, 0, 0, 639, 479, 1000));
		add_row(mk(OP_PROJECT, 0, 0, 0, 0, 480, 1000));
		add_row(mk(OP_PROJECT, 0, 0, 0, -8388608, -8388608, 8388607));
		add_row(mk(OP_LOAD, 320, 240, 1, 0, 0, 0));
		add_row(mk(OP_PROJECT, 0, 0, 0, 0, 0, 1));

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int p = 0; p < NPHASE; p++) begin
			if (p > 0)
				drain();
			for (int i = 0; i < 7; i++)
				write_reg(reg_idx_t'(i), phase_regs[p][i]);
			cfg_valid <= 1'b0;
			quiet = int'(p % 3 == 1);
			if (p == 0)
				foreach (directed_rows[i])
					send_item(directed_rows[i]);
			for (int i = 0; i < PER_PHASE; i++)
				send_item(random_item());
		end
		drain();

		$display("Covered %0d items over %0d register settings: %0d projected in view, %0d writes.",
			n_items, NPHASE, n_in_view, n_written);
		$display("Results checked: %0d, mismatches: %0d.", n_results, fails);
		if (fails == 0 && pending_q.size() == 0)
			$display("tb_point_projection_zbuffer: PASS");
		else
			$display("tb_point_projection_zbuffer: FAIL");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/ppz_pkg.sv
rtl/ppz_ram.sv
rtl/point_projection_zbuffer.sv
dv/tb_point_projection_zbuffer.sv
